### rtl/assert_macros.svh
// Assertion helpers. Each check is clocked on clock and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PME_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define PME_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pme_pkg.sv
package pme_pkg;

   localparam int NODES_DEFAULT = 256;
   localparam int LABEL_W = 8;
   localparam int CFG_W = 9;
   localparam int TOTAL_W = 9;
   localparam int BITS_W = 64;
   localparam int SEEN_W = 6;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      KIND_WRITE  = 3'd0,
      KIND_READ   = 3'd1,
      KIND_MERGE  = 3'd2,
      KIND_SPLIT  = 3'd3,
      KIND_SWITCH = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_BAD     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS_A,
      ST_PASS_B,
      ST_RESP
   } state_type;

endpackage

### rtl/pme_ram.sv
module pme_ram #(
   parameter int WIDTH = pme_pkg::LABEL_W,
   parameter int DEPTH = pme_pkg::NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/partition_move_engine_top.sv
// Channel | Direction | Beat carries
// req     | in        | tuser: kind; tdata: node_index, label_value, first_community,
//         |           |        second_community, split_bits
// rsp     | out       | tdata: status, read_label, community_total
// csr     | in        | data: node_count
//
// A write, a read, or a move that the first pass stops makes one pass over the n nodes in use;
// a move that needs the second pass makes two passes.
// A switch of a node in range with two or more communities always takes the second pass.
// The label memory port delivers one label per cycle to each pass. Reset clears the control
// state only and sets the node count to 256.
// A result waiting on rsp stalls only the final handoff of the next item.
`include "assert_macros.svh"

module partition_move_engine_top #(
   parameter int NODES = pme_pkg::NODES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Bits from low: node_index, label_value, first_community, second_community, split_bits.
   input  logic [pme_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Bits from low: kind.
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Bits from low: status, read_label, community_total, zero fill.
   output logic [pme_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pme_pkg::CFG_W-1:0]       csr_data
);

   localparam int AW = $clog2(NODES);
   localparam int CW = (AW + 1 > pme_pkg::CFG_W) ? AW + 1 : pme_pkg::CFG_W;
   localparam int LW = pme_pkg::LABEL_W;
   localparam int TW = pme_pkg::TOTAL_W;

   pme_pkg::state_type state_ff, state_in;

   logic [pme_pkg::CFG_W-1:0] node_count_ff, node_count_in;
   logic [2:0]                kind_ff, kind_in;
   logic [LW-1:0]             node_ff, node_in;
   logic [LW-1:0]             label_ff, label_in;
   logic [LW-1:0]             c1_ff, c1_in;
   logic [LW-1:0]             c2_ff, c2_in;
   logic [pme_pkg::BITS_W-1:0] bits_ff, bits_in;

   logic [CW-1:0]             issue_ff, issue_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [AW-1:0]             rd_addr_ff, rd_addr_in;
   logic [LW-1:0]             max_ff, max_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [LW-1:0]             own_ff, own_in;
   logic [TW-1:0]             np_ff, np_in;
   logic                      first_ff, first_in;
   logic [pme_pkg::SEEN_W-1:0] seen_ff, seen_in;

   logic [1:0]                res_status_ff, res_status_in;
   logic [LW-1:0]             res_read_ff, res_read_in;
   logic [TW-1:0]             res_total_ff, res_total_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [LW-1:0]             rsp_read_ff, rsp_read_in;
   logic [TW-1:0]             rsp_total_ff, rsp_total_in;

   logic [CW-1:0]             n_use;
   logic                      accept;
   logic                      in_pass;
   logic                      pass_end;
   logic                      pass_start;
   logic                      rsp_free;
   logic                      node_bad;
   logic                      hit_node;

   logic                      ram_rd_en;
   logic [AW-1:0]             ram_rd_addr;
   logic [LW-1:0]             ram_rd_data;
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [LW-1:0]             ram_wr_data;

   logic [LW-1:0]             proc_v;
   logic                      proc_wr;
   logic                      proc_cnt;
   logic                      proc_seen;
   logic [LW-1:0]             lo_c, hi_c;

   logic [TW-1:0]             np_a;
   logic [TW-1:0]             total_b;
   logic [1:0]                dec_status;
   logic [TW-1:0]             dec_total;
   logic [LW-1:0]             dec_read;
   logic                      dec_go_b;
   logic                      dec_sw_write;

   pme_ram #(
      .WIDTH (LW),
      .DEPTH (NODES)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (node_count_ff == '0) begin
         n_use = CW'(1);
      end else if (CW'(node_count_ff) > CW'(NODES)) begin
         n_use = CW'(NODES);
      end else begin
         n_use = CW'(node_count_ff);
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign in_pass    = (state_ff == pme_pkg::ST_PASS_A) || (state_ff == pme_pkg::ST_PASS_B);
   assign pass_end   = in_pass && (issue_ff == n_use) && !rd_valid_ff;
   assign pass_start = accept || (pass_end && (state_ff == pme_pkg::ST_PASS_A) && dec_go_b);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign node_bad   = CW'(node_ff) >= n_use;
   assign hit_node   = CW'(rd_addr_ff) == CW'(node_ff);
   assign lo_c       = (c1_ff < c2_ff) ? c1_ff : c2_ff;
   assign hi_c       = (c1_ff < c2_ff) ? c2_ff : c1_ff;
   assign np_a       = TW'(max_ff) + TW'(1);
   assign total_b    = TW'(max_ff) + TW'(1);

   always_comb begin
      proc_v    = ram_rd_data;
      proc_wr   = 1'b0;
      proc_cnt  = 1'b0;
      proc_seen = 1'b0;
      if (state_ff == pme_pkg::ST_PASS_A) begin
         proc_cnt = ram_rd_data == c1_ff;
         if ((kind_ff == pme_pkg::KIND_WRITE) && hit_node) begin
            proc_v  = label_ff;
            proc_wr = 1'b1;
         end
      end else begin
         case (kind_ff)
            pme_pkg::KIND_MERGE: begin
               proc_wr = 1'b1;
               if (ram_rd_data == hi_c) begin
                  proc_v = lo_c;
               end else if (ram_rd_data > hi_c) begin
                  proc_v = ram_rd_data - LW'(1);
               end
            end
            pme_pkg::KIND_SPLIT: begin
               if (ram_rd_data == c1_ff) begin
                  proc_cnt = 1'b1;
                  if (first_ff) begin
                     proc_seen = 1'b1;
                     if (bits_ff[seen_ff]) begin
                        proc_v  = np_ff[LW-1:0];
                        proc_wr = 1'b1;
                     end
                  end
               end
            end
            default: begin
               proc_cnt = ram_rd_data == own_ff;
               if (hit_node) begin
                  proc_v = c1_ff;
               end
            end
         endcase
      end
   end

   always_comb begin
      dec_status   = pme_pkg::STATUS_DONE;
      dec_total    = np_a;
      dec_read     = '0;
      dec_go_b     = 1'b0;
      dec_sw_write = 1'b0;
      if (state_ff == pme_pkg::ST_PASS_A) begin
         unique case (kind_ff)
            pme_pkg::KIND_WRITE: begin
               if (node_bad) dec_status = pme_pkg::STATUS_BAD;
            end
            pme_pkg::KIND_READ: begin
               if (node_bad) begin
                  dec_status = pme_pkg::STATUS_BAD;
               end else begin
                  dec_read = own_ff;
               end
            end
            pme_pkg::KIND_MERGE: begin
               if (np_a < TW'(2)) begin
                  dec_status = pme_pkg::STATUS_REFUSED;
               end else if ((c1_ff == c2_ff) || (TW'(c1_ff) >= np_a)
                            || (TW'(c2_ff) >= np_a)) begin
                  dec_status = pme_pkg::STATUS_BAD;
               end else begin
                  dec_go_b = 1'b1;
               end
            end
            pme_pkg::KIND_SPLIT: begin
               if (TW'(c1_ff) >= np_a) begin
                  dec_status = pme_pkg::STATUS_BAD;
               end else if ((cnt_ff < 2'd2) || (np_a > TW'(255))) begin
                  dec_status = pme_pkg::STATUS_REFUSED;
               end else begin
                  dec_go_b = 1'b1;
               end
            end
            pme_pkg::KIND_SWITCH: begin
               if (np_a < TW'(2)) begin
                  dec_status = pme_pkg::STATUS_REFUSED;
               end else if (node_bad) begin
                  dec_status = pme_pkg::STATUS_BAD;
               end else begin
                  dec_go_b = 1'b1;
               end
            end
            default: begin
               dec_status = pme_pkg::STATUS_BAD;
            end
         endcase
      end else begin
         dec_total = total_b;
         if (kind_ff == pme_pkg::KIND_SWITCH) begin
            if (cnt_ff < 2'd2) begin
               dec_status = pme_pkg::STATUS_REFUSED;
               dec_total  = np_ff;
            end else if ((TW'(c1_ff) >= np_ff) || (c1_ff == own_ff)) begin
               dec_status = pme_pkg::STATUS_BAD;
               dec_total  = np_ff;
            end else begin
               dec_sw_write = pass_end;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pme_pkg::ST_IDLE: begin
            if (accept) state_in = pme_pkg::ST_PASS_A;
         end
         pme_pkg::ST_PASS_A: begin
            if (pass_end) state_in = dec_go_b ? pme_pkg::ST_PASS_B : pme_pkg::ST_RESP;
         end
         pme_pkg::ST_PASS_B: begin
            if (pass_end) state_in = pme_pkg::ST_RESP;
         end
         pme_pkg::ST_RESP: begin
            if (rsp_free) state_in = pme_pkg::ST_IDLE;
         end
         default: begin
            state_in = pme_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = state_ff == pme_pkg::ST_IDLE;
      csr_ready   = state_ff == pme_pkg::ST_IDLE;
      ram_rd_en   = in_pass && (issue_ff < n_use);
      ram_rd_addr = issue_ff[AW-1:0];
      ram_wr_en   = (rd_valid_ff && proc_wr) || dec_sw_write;
      ram_wr_addr = dec_sw_write ? AW'(node_ff) : rd_addr_ff;
      ram_wr_data = dec_sw_write ? c1_ff : proc_v;
   end

   always_comb begin
      node_count_in = node_count_ff;
      kind_in       = kind_ff;
      node_in       = node_ff;
      label_in      = label_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      bits_in       = bits_ff;
      issue_in      = issue_ff;
      rd_valid_in   = ram_rd_en;
      rd_addr_in    = ram_rd_addr;
      max_in        = max_ff;
      cnt_in        = cnt_ff;
      own_in        = own_ff;
      np_in         = np_ff;
      first_in      = first_ff;
      seen_in       = seen_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_total_in  = res_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_total_in  = rsp_total_ff;

      if (csr_valid && csr_ready) begin
         node_count_in = csr_data;
      end

      if (accept) begin
         kind_in  = req_tuser;
         node_in  = req_tdata[7:0];
         label_in = req_tdata[15:8];
         c1_in    = req_tdata[23:16];
         c2_in    = req_tdata[31:24];
         bits_in  = req_tdata[95:32];
      end

      if (ram_rd_en) begin
         issue_in = issue_ff + CW'(1);
      end

      if (rd_valid_ff) begin
         if (proc_v > max_ff) max_in = proc_v;
         if (proc_cnt && (cnt_ff != 2'd2)) cnt_in = cnt_ff + 2'd1;
         if ((state_ff == pme_pkg::ST_PASS_A) && hit_node) own_in = ram_rd_data;
         if ((state_ff == pme_pkg::ST_PASS_B) && proc_cnt) first_in = 1'b1;
         if (proc_seen) seen_in = seen_ff + pme_pkg::SEEN_W'(1);
      end

      if (pass_end) begin
         res_status_in = dec_status;
         res_read_in   = dec_read;
         res_total_in  = dec_total;
         if (state_ff == pme_pkg::ST_PASS_A) np_in = np_a;
      end

      if (pass_start) begin
         issue_in = '0;
         max_in   = '0;
         cnt_in   = '0;
         first_in = 1'b0;
         seen_in  = '0;
      end

      if ((state_ff == pme_pkg::ST_RESP) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_read_in   = res_read_ff;
         rsp_total_in  = res_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pme_pkg::ST_IDLE;
         node_count_ff <= pme_pkg::CFG_W'(256);
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         issue_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_ff      <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      node_ff       <= node_in;
      label_ff      <= label_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      bits_ff       <= bits_in;
      rd_addr_ff    <= rd_addr_in;
      max_ff        <= max_in;
      cnt_ff        <= cnt_in;
      own_ff        <= own_in;
      np_ff         <= np_in;
      first_ff      <= first_in;
      seen_ff       <= seen_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_total_ff, rsp_read_ff, rsp_status_ff};

   `PME_ASSERT_IMPL(a_read_in_pass, rd_valid_ff, in_pass, "Label read data outside a pass.")
   `PME_ASSERT_NEXT(a_accept_scan, accept, state_ff == pme_pkg::ST_PASS_A, "Beat not scanned.")
   `PME_ASSERT_IMPL(a_issue_bound, in_pass, issue_ff <= n_use, "Scan ran past node count.")
   `PME_ASSERT_IMPL(a_write_scope, ram_wr_en, in_pass, "Label write outside a pass.")

endmodule

### test/community_label_checker.sv
module community_label_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pme_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [2:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pme_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pme_pkg::CFG_W-1:0]       csr_data,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      pme_pkg::status_type status;
      logic [7:0]          read_label;
      logic [8:0]          total;
   } move_result_type;

   logic [7:0]        label_copy [pme_pkg::NODES_DEFAULT];
   logic [8:0]        node_setting;
   move_result_type   result_queue [$];

   initial begin
      fail_count = 0;
      pending = 0;
      node_setting = 9'(pme_pkg::NODES_DEFAULT);
   end

   function automatic int nodes_in_use();
      if (node_setting == 0) return 1;
      if (node_setting > pme_pkg::NODES_DEFAULT) return pme_pkg::NODES_DEFAULT;
      return int'(node_setting);
   endfunction

   function automatic int community_span(int n);
      int top_label = 0;
      for (int i = 0; i < n; i++) begin
         if (label_copy[i] > top_label) top_label = int'(label_copy[i]);
      end
      return top_label + 1;
   endfunction

   function automatic int members_in(int n, int community);
      int count = 0;
      for (int i = 0; i < n; i++) begin
         if (label_copy[i] == community) count++;
      end
      return count;
   endfunction

   function automatic move_result_type apply_beat(logic [2:0] kind, logic [7:0] node,
      logic [7:0] label_value, logic [7:0] c_a, logic [7:0] c_b, logic [63:0] bits);
      move_result_type r;
      int n;
      int span;
      int own;
      int seen;
      int lo;
      int hi;
      n = nodes_in_use();
      r.status = pme_pkg::STATUS_DONE;
      r.read_label = '0;
      case (kind)
         pme_pkg::KIND_WRITE: begin
            if (node >= n) r.status = pme_pkg::STATUS_BAD;
            else label_copy[node] = label_value;
         end
         pme_pkg::KIND_READ: begin
            if (node >= n) r.status = pme_pkg::STATUS_BAD;
            else r.read_label = label_copy[node];
         end
         pme_pkg::KIND_MERGE: begin
            span = community_span(n);
            if (span < 2) begin
               r.status = pme_pkg::STATUS_REFUSED;
            end else if (c_a == c_b || c_a >= span || c_b >= span) begin
               r.status = pme_pkg::STATUS_BAD;
            end else begin
               lo = (c_a < c_b) ? int'(c_a) : int'(c_b);
               hi = (c_a < c_b) ? int'(c_b) : int'(c_a);
               for (int i = 0; i < n; i++) begin
                  if (label_copy[i] == hi) label_copy[i] = 8'(lo);
                  else if (label_copy[i] > hi) label_copy[i] = label_copy[i] - 8'd1;
               end
            end
         end
         pme_pkg::KIND_SPLIT: begin
            span = community_span(n);
            if (c_a >= span) begin
               r.status = pme_pkg::STATUS_BAD;
            end else if (members_in(n, int'(c_a)) < 2 || span > 255) begin
               r.status = pme_pkg::STATUS_REFUSED;
            end else begin
               seen = 0;
               for (int i = 0; i < n; i++) begin
                  if (label_copy[i] == c_a) begin
                     if (seen != 0 && bits[(seen - 1) & 63]) label_copy[i] = 8'(span);
                     seen++;
                  end
               end
            end
         end
         pme_pkg::KIND_SWITCH: begin
            span = community_span(n);
            if (span < 2) begin
               r.status = pme_pkg::STATUS_REFUSED;
            end else if (node >= n) begin
               r.status = pme_pkg::STATUS_BAD;
            end else begin
               own = int'(label_copy[node]);
               if (members_in(n, own) < 2) r.status = pme_pkg::STATUS_REFUSED;
               else if (c_a >= span || c_a == own) r.status = pme_pkg::STATUS_BAD;
               else label_copy[node] = c_a;
            end
         end
         default: r.status = pme_pkg::STATUS_BAD;
      endcase
      r.total = 9'(community_span(n));
      return r;
   endfunction

   always @(posedge clock) begin
      move_result_type want;
      if (reset) begin
         node_setting = 9'(pme_pkg::NODES_DEFAULT);
         result_queue.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               $error("rsp beat arrived with no result pending");
               fail_count++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[9:2] !== want.read_label) begin
                  $error("read_label: expected %0d, got %0d", want.read_label, rsp_tdata[9:2]);
                  fail_count++;
               end
               if (rsp_tdata[18:10] !== want.total) begin
                  $error("community_total: expected %0d, got %0d", want.total,
                     rsp_tdata[18:10]);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) node_setting = csr_data;
         if (req_tvalid && req_tready) begin
            result_queue.push_back(apply_beat(req_tuser, req_tdata[7:0], req_tdata[15:8],
               req_tdata[23:16], req_tdata[31:24], req_tdata[95:32]));
         end
         pending <= result_queue.size();
      end
   end

endmodule

### test/partition_move_engine_top_test.sv
module partition_move_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 500;
   localparam int CALM_ITEMS = 80;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT = 2000000;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pme_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic [2:0]                       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pme_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [pme_pkg::CFG_W-1:0]        csr_data = '0;
   int                               fail_count;
   int                               pending;
   int                               cycle_count = 0;
   int                               active_n = pme_pkg::NODES_DEFAULT;
   bit                               quiet = 1'b0;

   partition_move_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   community_label_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!quiet) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom());
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_item(input logic [2:0] kind, input logic [7:0] node,
      input logic [7:0] label_value, input logic [7:0] c_a, input logic [7:0] c_b,
      input logic [63:0] bits);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {bits, c_b, c_a, label_value, node};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_nodes(input logic [pme_pkg::CFG_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (value == 0) active_n = 1;
      else if (value > pme_pkg::NODES_DEFAULT) active_n = pme_pkg::NODES_DEFAULT;
      else active_n = int'(value);
   endtask

   initial begin
      int issued;
      int phase;
      int pick;
      int moves;
      int span_guess;
      int top_label;
      logic [pme_pkg::CFG_W-1:0] setting;
      logic [7:0] node;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Grow the node count one at a time so that every label is written before it is used.
      set_nodes('0);
      send_item(pme_pkg::KIND_WRITE, 8'd0, 8'($urandom_range(0, 5)), rnd8(), rnd8(), rnd64());
      for (int k = 2; k <= pme_pkg::NODES_DEFAULT; k++) begin
         set_nodes(pme_pkg::CFG_W'(k));
         send_item(pme_pkg::KIND_WRITE, 8'(k - 1), 8'($urandom_range(0, 5)), rnd8(), rnd8(),
            rnd64());
      end

      set_nodes(pme_pkg::CFG_W'(4));
      for (int i = 0; i < 4; i++) begin
         send_item(pme_pkg::KIND_WRITE, 8'(i), 8'd0, rnd8(), rnd8(), rnd64());
      end
      send_item(pme_pkg::KIND_MERGE, rnd8(), rnd8(), 8'd0, 8'd1, rnd64());
      send_item(pme_pkg::KIND_SWITCH, 8'd0, rnd8(), 8'd1, rnd8(), rnd64());
      send_item(pme_pkg::KIND_SPLIT, rnd8(), rnd8(), 8'd0, rnd8(), '1);
      send_item(pme_pkg::KIND_SPLIT, rnd8(), rnd8(), 8'd0, rnd8(), '1);
      send_item(pme_pkg::KIND_SPLIT, rnd8(), rnd8(), 8'd5, rnd8(), rnd64());
      send_item(pme_pkg::KIND_SPLIT, rnd8(), rnd8(), 8'd1, rnd8(), '0);
      send_item(pme_pkg::KIND_SWITCH, 8'd0, rnd8(), 8'd1, rnd8(), rnd64());
      send_item(pme_pkg::KIND_SWITCH, 8'd1, rnd8(), 8'd1, rnd8(), rnd64());
      send_item(pme_pkg::KIND_SWITCH, 8'd1, rnd8(), 8'd7, rnd8(), rnd64());
      send_item(pme_pkg::KIND_SWITCH, 8'd4, rnd8(), 8'd0, rnd8(), rnd64());
      send_item(pme_pkg::KIND_SWITCH, 8'd1, rnd8(), 8'd0, rnd8(), rnd64());
      send_item(pme_pkg::KIND_MERGE, rnd8(), rnd8(), 8'd1, 8'd1, rnd64());
      send_item(pme_pkg::KIND_MERGE, rnd8(), rnd8(), 8'd0, 8'd9, rnd64());
      send_item(pme_pkg::KIND_MERGE, rnd8(), rnd8(), 8'd1, 8'd0, rnd64());
      send_item(pme_pkg::KIND_WRITE, 8'd3, 8'd255, rnd8(), rnd8(), rnd64());
      send_item(pme_pkg::KIND_READ, 8'd3, rnd8(), rnd8(), rnd8(), rnd64());
      send_item(pme_pkg::KIND_SPLIT, rnd8(), rnd8(), 8'd0, rnd8(), '1);
      send_item(pme_pkg::KIND_WRITE, 8'd7, rnd8(), rnd8(), rnd8(), rnd64());
      send_item(pme_pkg::KIND_READ, 8'd9, rnd8(), rnd8(), rnd8(), rnd64());
      for (int k = int'(pme_pkg::KIND_SWITCH) + 1; k < 8; k++) begin
         send_item(3'(k), rnd8(), rnd8(), rnd8(), rnd8(), rnd64());
      end

      issued = 0;
      phase = 0;
      while (issued < RANDOM_ITEMS) begin
         case (phase)
            0: setting = pme_pkg::CFG_W'(511);
            1: setting = pme_pkg::CFG_W'(1);
            default: begin
               pick = $urandom_range(0, 19);
               if (pick == 0) begin
                  setting = pme_pkg::CFG_W'(pme_pkg::NODES_DEFAULT);
               end else if (pick == 1) begin
                  setting = pme_pkg::CFG_W'($urandom_range(pme_pkg::NODES_DEFAULT + 1, 511));
               end else if (pick == 2) begin
                  setting = '0;
               end else begin
                  setting = pme_pkg::CFG_W'($urandom_range(2, 20));
               end
            end
         endcase
         set_nodes(setting);
         if (active_n <= 32) begin
            top_label = $urandom_range(0, (active_n < 7) ? active_n - 1 : 6);
            for (int i = 0; i < active_n; i++) begin
               send_item(pme_pkg::KIND_WRITE, 8'(i), 8'($urandom_range(0, top_label)), rnd8(),
                  rnd8(), rnd64());
            end
            issued += active_n;
            span_guess = top_label + 1;
            moves = $urandom_range(8, 24);
         end else begin
            span_guess = 16;
            moves = $urandom_range(4, 8);
         end
         for (int m = 0; m < moves; m++) begin
            pick = $urandom_range(0, 99);
            node = 8'($urandom_range(0, active_n));
            if (pick < 28) begin
               send_item(pme_pkg::KIND_MERGE, rnd8(), rnd8(), 8'($urandom_range(0, span_guess)),
                  8'($urandom_range(0, span_guess)), rnd64());
               if (span_guess > 1) span_guess--;
            end else if (pick < 56) begin
               send_item(pme_pkg::KIND_SPLIT, rnd8(), rnd8(), 8'($urandom_range(0, span_guess)),
                  rnd8(), ($urandom_range(0, 1) == 0) ? rnd64() & rnd64() : rnd64());
               if (span_guess < active_n) span_guess++;
            end else if (pick < 82) begin
               send_item(pme_pkg::KIND_SWITCH, node, rnd8(), 8'($urandom_range(0, span_guess)),
                  rnd8(), rnd64());
            end else if (pick < 90) begin
               send_item(pme_pkg::KIND_READ, node, rnd8(), rnd8(), rnd8(), rnd64());
            end else if (pick < 95) begin
               send_item(pme_pkg::KIND_WRITE, node, 8'($urandom_range(0, span_guess)), rnd8(),
                  rnd8(), rnd64());
            end else begin
               send_item(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8(), rnd8(), rnd64());
            end
            issued++;
         end
         if (issued > RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
